// ===== src/htfsm_pkg.sv =====
// Shared constants and types for the half-turn flip speed meter.
package htfsm_pkg;

   // Default parameter values.
   localparam int SAMPLE_BITS_DEF  = 10;
   localparam int COUNTER_BITS_DEF = 16;

   // Fixed field widths.
   localparam int THRESH_BITS   = 10;
   localparam int GAIN_BITS     = 16;
   localparam int NUM_BITS      = 20;
   localparam int FLIP_BITS     = 16;
   localparam int SPEED_BITS    = 27;
   localparam int PROD_BITS     = FLIP_BITS + GAIN_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_FLIP_THRESHOLD         = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COUNT_SPEED_GAIN       = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_SPEED_NUMERATOR = 2'd2;

   // Configuration reset values.
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd700;
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd600;
   localparam logic [NUM_BITS-1:0]    NUM_RESET    = 20'd150000;

   // Count speed saturates symmetrically at this magnitude.
   localparam logic [PROD_BITS-1:0] SPEED_LIMIT = 32'd39321600;

   // Request type codes.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CHECK  = 1'b1;

   typedef logic [FLIP_BITS-1:0] flip_type;

endpackage

// ===== src/htfsm_multiplier.sv =====
// Bit-serial shift-add multiplier, one gain bit per cycle, most significant first.
module htfsm_multiplier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [htfsm_pkg::FLIP_BITS-1:0]     mag,
   input  logic [htfsm_pkg::GAIN_BITS-1:0]     gain,
   output logic                                busy,
   output logic [htfsm_pkg::PROD_BITS-1:0]     product
);

   localparam int CNT_BITS = $clog2(htfsm_pkg::GAIN_BITS + 1);

   logic [htfsm_pkg::PROD_BITS-1:0] acc_ff, acc_in;
   logic [htfsm_pkg::FLIP_BITS-1:0] mag_ff;
   logic [htfsm_pkg::GAIN_BITS-1:0] gain_ff;
   logic [CNT_BITS-1:0]             count_ff;

   // Double the partial sum and add the multiplicand when the gain bit is set.
   always_comb begin
      acc_in = {acc_ff[htfsm_pkg::PROD_BITS-2:0], 1'b0};
      if (gain_ff[htfsm_pkg::GAIN_BITS-1]) begin
         acc_in = acc_in + htfsm_pkg::PROD_BITS'(mag_ff);
      end
   end

   // Control counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_BITS'(htfsm_pkg::GAIN_BITS);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         mag_ff  <= mag;
         gain_ff <= gain;
      end else if (count_ff != '0) begin
         acc_ff  <= acc_in;
         gain_ff <= {gain_ff[htfsm_pkg::GAIN_BITS-2:0], 1'b0};
      end
   end

   assign busy    = (count_ff != '0);
   assign product = acc_ff;

endmodule

// ===== src/htfsm_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module htfsm_divider #(
   parameter int DIV_BITS = htfsm_pkg::COUNTER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [htfsm_pkg::NUM_BITS-1:0]   numerator,
   input  logic [DIV_BITS-1:0]              divisor,
   output logic                             busy,
   output logic [htfsm_pkg::NUM_BITS-1:0]   quotient
);

   localparam int CNT_BITS = $clog2(htfsm_pkg::NUM_BITS + 1);

   logic [DIV_BITS-1:0]              rem_ff, rem_in;
   logic [DIV_BITS-1:0]              div_ff;
   logic [htfsm_pkg::NUM_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]              count_ff;
   logic [DIV_BITS:0]                trial;
   logic [DIV_BITS:0]                diff;

   // The numerator shifts out at the top while quotient bits enter at the bottom.
   always_comb begin
      trial = {rem_ff, quo_ff[htfsm_pkg::NUM_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      if (!diff[DIV_BITS]) begin
         rem_in = diff[DIV_BITS-1:0];
         quo_in = {quo_ff[htfsm_pkg::NUM_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[DIV_BITS-1:0];
         quo_in = {quo_ff[htfsm_pkg::NUM_BITS-2:0], 1'b0};
      end
   end

   // Control counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_BITS'(htfsm_pkg::NUM_BITS);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   // Remainder and quotient registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= numerator;
      end else if (count_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== src/half_turn_flip_speed_meter_core.sv =====
// Top level of the half-turn flip counter with count and period speed estimates.
//
// A sample transaction (type 0) is accepted and its result is in the output
// register on the next cycle; another transaction may be accepted right away,
// so samples stream at one per cycle while the consumer keeps up. A speed check
// transaction (type 1) runs the bit-serial divider, which retires one quotient bit
// per cycle, and then loads the output register; the next transaction can be
// accepted as soon as the result appears. The bit-serial multiplier for the count
// speed runs alongside the divider. No request is accepted while a check is in
// progress or while the output register is full and stalled. Configuration writes
// are always accepted.
module half_turn_flip_speed_meter_core #(
   parameter int SAMPLE_BITS  = htfsm_pkg::SAMPLE_BITS_DEF,
   parameter int COUNTER_BITS = htfsm_pkg::COUNTER_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Request channel
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_type,
   input  logic [SAMPLE_BITS-1:0]                     req_sample,
   // Response channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [htfsm_pkg::FLIP_BITS-1:0]     rsp_flip_count,
   output logic signed [htfsm_pkg::SPEED_BITS-1:0]    rsp_count_speed,
   output logic [htfsm_pkg::NUM_BITS-1:0]             rsp_period_speed,
   output logic                                       rsp_period_valid,
   // Configuration channel
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [htfsm_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [htfsm_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   localparam int CMP_BITS = (SAMPLE_BITS > htfsm_pkg::THRESH_BITS) ?
                             SAMPLE_BITS : htfsm_pkg::THRESH_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   // Configuration registers
   logic [htfsm_pkg::THRESH_BITS-1:0] thr_ff;
   logic [htfsm_pkg::GAIN_BITS-1:0]   gain_ff;
   logic [htfsm_pkg::NUM_BITS-1:0]    num_ff;

   // Measurement state
   logic [SAMPLE_BITS-1:0]  prev_ff, prev2_ff;
   logic [1:0]              primed_ff, primed_in;
   htfsm_pkg::flip_type     net_ff, net_in;
   htfsm_pkg::flip_type     last_chk_ff;
   logic [COUNTER_BITS-1:0] tsf_ff, tsf_in;
   logic [COUNTER_BITS-1:0] tpf_ff, tpf_in;
   logic                    state_ff;
   logic                    neg_ff;

   // Output register
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic signed [htfsm_pkg::FLIP_BITS-1:0]    rsp_flip_ff;
   logic signed [htfsm_pkg::SPEED_BITS-1:0]   rsp_cspd_ff, cspd_in;
   logic [htfsm_pkg::NUM_BITS-1:0]            rsp_pspd_ff;
   logic                                      rsp_pvld_ff;

   // Handshake and sequencing
   logic req_accept;
   logic smp_load;
   logic chk_start;
   logic calc_done;
   logic out_load;

   // Sample comparison
   logic                   smp_up;
   logic [SAMPLE_BITS-1:0] smp_mag;
   logic                   smp_flip;

   // Check setup and arithmetic units
   htfsm_pkg::flip_type               chk_diff, chk_mag;
   logic                              mul_busy, div_busy;
   logic [htfsm_pkg::PROD_BITS-1:0]   mul_product, sat_mag;
   logic [htfsm_pkg::NUM_BITS-1:0]    div_quotient;

   // Handshake.
   assign req_stall  = (state_ff == ST_CALC) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign smp_load   = req_accept && (req_type == htfsm_pkg::REQ_SAMPLE);
   assign chk_start  = req_accept && (req_type == htfsm_pkg::REQ_CHECK);
   assign calc_done  = (state_ff == ST_CALC) && !mul_busy && !div_busy;
   assign out_load   = smp_load || calc_done;
   assign csr_ready  = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= htfsm_pkg::THRESH_RESET;
         gain_ff <= htfsm_pkg::GAIN_RESET;
         num_ff  <= htfsm_pkg::NUM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            htfsm_pkg::CSR_FLIP_THRESHOLD: begin
               thr_ff <= csr_data[htfsm_pkg::THRESH_BITS-1:0];
            end
            htfsm_pkg::CSR_COUNT_SPEED_GAIN: begin
               gain_ff <= csr_data[htfsm_pkg::GAIN_BITS-1:0];
            end
            htfsm_pkg::CSR_PERIOD_SPEED_NUMERATOR: begin
               num_ff <= csr_data[htfsm_pkg::NUM_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Jump between this sample and the one two samples earlier.
   always_comb begin
      smp_up   = (req_sample > prev2_ff);
      smp_mag  = smp_up ? (req_sample - prev2_ff) : (prev2_ff - req_sample);
      smp_flip = (primed_ff == 2'd2) &&
                 (CMP_BITS'(smp_mag) > CMP_BITS'(thr_ff)) &&
                 (tsf_ff != '0);
   end

   // Flip counting and interval tracking on a sample transaction.
   always_comb begin
      primed_in = primed_ff;
      net_in    = net_ff;
      tsf_in    = tsf_ff;
      tpf_in    = tpf_ff;
      if (smp_load) begin
         if (primed_ff != 2'd2) begin
            primed_in = primed_ff + 2'd1;
         end else if (smp_flip) begin
            net_in = smp_up ? (net_ff + htfsm_pkg::FLIP_BITS'(1))
                            : (net_ff - htfsm_pkg::FLIP_BITS'(1));
            tpf_in = tsf_ff;
            tsf_in = '0;
         end else if (tsf_ff != '1) begin
            tsf_in = tsf_ff + COUNTER_BITS'(1);
         end
      end
   end

   // Flips since the last check, split into sign and magnitude.
   always_comb begin
      chk_diff = net_ff - last_chk_ff;
      chk_mag  = chk_diff[htfsm_pkg::FLIP_BITS-1] ? (~chk_diff + htfsm_pkg::FLIP_BITS'(1))
                                                  : chk_diff;
   end

   // Saturate the product and restore its sign.
   always_comb begin
      sat_mag = (mul_product > htfsm_pkg::SPEED_LIMIT) ? htfsm_pkg::SPEED_LIMIT
                                                       : mul_product;
      cspd_in = neg_ff ? -$signed(sat_mag[htfsm_pkg::SPEED_BITS-1:0])
                       : $signed(sat_mag[htfsm_pkg::SPEED_BITS-1:0]);
   end

   // Measurement state and sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         prev2_ff    <= '0;
         primed_ff   <= '0;
         net_ff      <= '0;
         last_chk_ff <= '0;
         tsf_ff      <= '0;
         tpf_ff      <= '0;
         state_ff    <= ST_IDLE;
      end else begin
         primed_ff <= primed_in;
         net_ff    <= net_in;
         tsf_ff    <= tsf_in;
         tpf_ff    <= tpf_in;
         if (smp_load) begin
            prev2_ff <= prev_ff;
            prev_ff  <= req_sample;
         end
         if (chk_start) begin
            last_chk_ff <= net_ff;
            state_ff    <= ST_CALC;
         end else if (calc_done) begin
            state_ff <= ST_IDLE;
         end
      end
   end

   // Sign of the flip difference for the running check.
   always_ff @(posedge clock) begin
      if (chk_start) begin
         neg_ff <= chk_diff[htfsm_pkg::FLIP_BITS-1];
      end
   end

   // Count speed multiplier.
   htfsm_multiplier u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (chk_start),
      .mag     (chk_mag),
      .gain    (gain_ff),
      .busy    (mul_busy),
      .product (mul_product)
   );

   // Period speed divider.
   htfsm_divider #(
      .DIV_BITS (COUNTER_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (chk_start),
      .numerator (num_ff),
      .divisor   (tpf_ff),
      .busy      (div_busy),
      .quotient  (div_quotient)
   );

   // Output valid.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_cspd_ff  <= '0;
         rsp_pspd_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (calc_done) begin
            rsp_cspd_ff <= cspd_in;
            rsp_pspd_ff <= (tpf_ff != '0) ? div_quotient : '0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_flip_ff <= $signed(net_in);
         rsp_pvld_ff <= (tpf_in != '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_flip_count   = rsp_flip_ff;
   assign rsp_count_speed  = rsp_cspd_ff;
   assign rsp_period_speed = rsp_pspd_ff;
   assign rsp_period_valid = rsp_pvld_ff;

   // A new result is only written when the output register is free.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a pending transaction");

   // A check transaction starts the arithmetic units.
   a_chk_busy: assert property (@(posedge clock) disable iff (reset)
      chk_start |=> (state_ff == ST_CALC) && mul_busy && div_busy)
      else $error("check did not start the arithmetic units");

   // Once a flip interval is captured it never returns to zero.
   a_tpf_sticky: assert property (@(posedge clock) disable iff (reset)
      (tpf_ff != '0) |=> (tpf_ff != '0))
      else $error("captured interval returned to zero");

   // Without a captured interval the period speed stays zero.
   a_pspd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pvld_ff) |-> (rsp_pspd_ff == '0))
      else $error("period speed nonzero without a valid interval");

endmodule
